@@ design/ffba_pkg.sv @@
package ffba_pkg;

  // Widths fixed by the request and result fields.
  localparam int DATA_W = 16;
  // The dividend carries one extra bit for the rounding addend.
  localparam int DIV_W  = DATA_W + 1;

  // Header kinds as stored in the header memory.
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_FREE = 2'd1;
  localparam logic [1:0] KIND_USED = 2'd2;

  // Request modes.
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_DIV,
    OP_F_CHECK,
    OP_F_HEAD,
    OP_F_NEXT,
    OP_F_NCLR,
    OP_F_WSTART,
    OP_F_WALK,
    OP_F_PCLR,
    OP_A_START,
    OP_A_SCAN,
    OP_A_MARK
  } dp_op_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_A_START,
    S_A_SCAN,
    S_A_MARK,
    S_F_CHECK,
    S_F_HEAD,
    S_F_NEXT,
    S_F_NCLR,
    S_F_WSTART,
    S_F_WALK,
    S_F_PCLR
  } state_t;

  // Command from the controller to the datapath.
  typedef struct packed {
    dp_op_t  op;
    logic    res;
    status_t status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic mode_free;
    logic addr_ok;
    logic rd_used;
    logic rd_free;
    logic fit;
    logic scan_end;
    logic nxt_in;
    logic h_zero;
    logic walk_more;
    logic prev_hit;
    logic clr_last;
  } sts_t;

endpackage

@@ design/first_fit_block_allocator.sv @@
// First-fit heap allocator over HEAP_BLOCKS blocks of BLOCK_BYTES bytes. After reset the
// header memory is swept once with busy high. An allocate request divides the byte count
// by the block size, then visits each segment header up to and including the first large
// enough free segment; a free request checks the address, merges the freed segment with
// free neighbours and walks each segment lying below it. The walks are bound by the single
// read port of the header memory, which yields one header per cycle. Each request gives one
// result on out_strobe for a single cycle; the receiver cannot stall it, so it must take it
// then.
module first_fit_block_allocator #(
  parameter int BLOCK_BYTES = 64,
  parameter int HEAP_BLOCKS = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_mode,
  input  logic [ffba_pkg::DATA_W-1:0] in_request_bytes,
  input  logic [ffba_pkg::DATA_W-1:0] in_free_address,
  output logic                        out_strobe,
  output logic [1:0]                  out_status,
  output logic [ffba_pkg::DATA_W-1:0] out_payload_address
);
  import ffba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ffba_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  ffba_dp #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .HEAP_BLOCKS (HEAP_BLOCKS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_mode             (in_mode),
    .in_request_bytes    (in_request_bytes),
    .in_free_address     (in_free_address),
    .out_strobe          (out_strobe),
    .out_status          (out_status),
    .out_payload_address (out_payload_address)
  );

  // One result per request; the strobe is never high on adjacent cycles.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for two cycles");
  // A failed request never reports an address.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status != ST_OK) |-> (out_payload_address == '0))
    else $error("address reported with a failure status");

endmodule

@@ design/ffba_ram.sv @@
module ffba_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

  assign rdata = rd_data_r;

endmodule

@@ design/ffba_ctrl.sv @@
module ffba_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  ffba_pkg::sts_t sts,
  output ffba_pkg::cmd_t cmd
);
  import ffba_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:    if (sts.clr_last) state_nxt = S_IDLE;
      S_IDLE:     if (start) state_nxt = S_DIV;
      S_DIV: begin
        if (sts.div_done) state_nxt = sts.mode_free ? S_F_CHECK : S_A_START;
      end
      S_A_START:  state_nxt = S_A_SCAN;
      S_A_SCAN: begin
        if (sts.fit) state_nxt = S_A_MARK;
        else if (sts.scan_end) state_nxt = S_IDLE;
      end
      S_A_MARK:   state_nxt = S_IDLE;
      S_F_CHECK:  state_nxt = sts.addr_ok ? S_F_HEAD : S_IDLE;
      S_F_HEAD: begin
        if (!sts.rd_used) state_nxt = S_IDLE;
        else if (sts.nxt_in) state_nxt = S_F_NEXT;
        else state_nxt = S_F_WSTART;
      end
      S_F_NEXT:   state_nxt = sts.rd_free ? S_F_NCLR : S_F_WSTART;
      S_F_NCLR:   state_nxt = S_F_WSTART;
      S_F_WSTART: state_nxt = sts.h_zero ? S_IDLE : S_F_WALK;
      S_F_WALK: begin
        if (sts.walk_more) state_nxt = S_F_WALK;
        else if (sts.prev_hit) state_nxt = S_F_PCLR;
        else state_nxt = S_IDLE;
      end
      S_F_PCLR:   state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd.op     = OP_NONE;
    cmd.res    = 1'b0;
    cmd.status = ST_OK;
    unique case (state_r)
      S_CLEAR:   cmd.op = OP_CLEAR;
      S_IDLE:    if (start) cmd.op = OP_LOAD;
      S_DIV:     cmd.op = OP_DIV;
      S_A_START: cmd.op = OP_A_START;
      S_A_SCAN: begin
        cmd.op = OP_A_SCAN;
        if (!sts.fit && sts.scan_end) begin
          cmd.res    = 1'b1;
          cmd.status = ST_NOFIT;
        end
      end
      S_A_MARK: begin
        cmd.op  = OP_A_MARK;
        cmd.res = 1'b1;
      end
      S_F_CHECK: begin
        cmd.op = OP_F_CHECK;
        if (!sts.addr_ok) begin
          cmd.res    = 1'b1;
          cmd.status = ST_INVALID;
        end
      end
      S_F_HEAD: begin
        cmd.op = OP_F_HEAD;
        if (!sts.rd_used) begin
          cmd.res    = 1'b1;
          cmd.status = ST_INVALID;
        end
      end
      S_F_NEXT:  cmd.op = OP_F_NEXT;
      S_F_NCLR:  cmd.op = OP_F_NCLR;
      S_F_WSTART: begin
        cmd.op  = OP_F_WSTART;
        cmd.res = sts.h_zero;
      end
      S_F_WALK: begin
        cmd.op  = OP_F_WALK;
        cmd.res = !sts.walk_more && !sts.prev_hit;
      end
      S_F_PCLR: begin
        cmd.op  = OP_F_PCLR;
        cmd.res = 1'b1;
      end
      default:   cmd.op = OP_NONE;
    endcase
  end

  // A request is never taken while a walk or the clearing pass runs.
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == S_DIV))
    else $error("accepted request did not enter the divider");
  // A result leaves the controller idle on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res |=> !busy)
    else $error("controller busy after issuing a result");

endmodule

@@ design/ffba_dp.sv @@
module ffba_dp #(
  parameter int BLOCK_BYTES = 64,
  parameter int HEAP_BLOCKS = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ffba_pkg::cmd_t                cmd,
  output ffba_pkg::sts_t                sts,
  input  logic                          in_mode,
  input  logic [ffba_pkg::DATA_W-1:0]   in_request_bytes,
  input  logic [ffba_pkg::DATA_W-1:0]   in_free_address,
  output logic                          out_strobe,
  output logic [1:0]                    out_status,
  output logic [ffba_pkg::DATA_W-1:0]   out_payload_address
);
  import ffba_pkg::*;

  localparam int AW  = $clog2(HEAP_BLOCKS);
  localparam int PW  = $clog2(HEAP_BLOCKS + 1);
  localparam int SW  = AW;
  localparam int WW  = 2 + SW;
  localparam int LB  = $clog2(BLOCK_BYTES);
  localparam int RB  = LB + 1;
  localparam int MW  = PW + $clog2(BLOCK_BYTES) + 2;
  localparam int SH  = DIV_W + LB;
  localparam int PRW = 2 * DIV_W + 1;
  localparam logic [DIV_W-1:0] BB_M1   = DIV_W'(BLOCK_BYTES - 1);
  localparam logic [DIV_W:0]   MAGIC   =
    (DIV_W + 1)'(((64'd1 << SH) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES));
  localparam logic [PW-1:0]    HEAP_P  = PW'(HEAP_BLOCKS);
  localparam logic [SW-1:0]    FULL_SZ = SW'(HEAP_BLOCKS - 1);

  logic              mode_r;
  logic [DIV_W-1:0]  x_r;
  logic [DIV_W-1:0]  q_r;
  logic [RB-1:0]     rem_r;
  logic              cnt_r;
  logic [PW-1:0]     p_r;
  logic [PW-1:0]     h_r;
  logic [SW-1:0]     size_h_r;
  logic              out_strobe_r;
  status_t           out_status_r;
  logic [DATA_W-1:0] out_addr_r;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [WW-1:0]     wdata;
  logic [AW-1:0]     raddr;
  logic [WW-1:0]     rdata;
  logic [1:0]        rd_kind;
  logic [SW-1:0]     rd_size;
  logic [PRW-1:0]    prod;
  logic [DIV_W-1:0]  quot;
  logic [DIV_W-1:0]  rem_calc;
  logic [PW-1:0]     adv;
  logic [DIV_W-1:0]  h_full;
  logic [MW-1:0]     addr_full;
  logic [SW-1:0]     merged;

  ffba_ram #(.WIDTH(WW), .DEPTH(HEAP_BLOCKS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_kind = rdata[WW-1:SW];
  assign rd_size = rdata[SW-1:0];

  // Division by the block size through its reciprocal: the quotient in the first step and
  // the remainder in the second.
  assign prod     = PRW'(x_r) * PRW'(MAGIC);
  assign quot     = DIV_W'(prod >> SH);
  assign rem_calc = x_r - DIV_W'(q_r * DIV_W'(BLOCK_BYTES));

  // Address of the header that follows the one just read.
  assign adv    = ((cmd.op == OP_F_HEAD) ? h_r : p_r) + PW'(rd_size) + PW'(1);
  assign h_full = q_r - DIV_W'(1);
  assign merged = size_h_r + rd_size + SW'(1);

  // Payload offset just after the header at p_r.
  assign addr_full = (MW'(p_r) + MW'(1)) * MW'(BLOCK_BYTES);

  // Status to the controller.
  always_comb begin
    sts.div_done  = cnt_r;
    sts.mode_free = (mode_r == MODE_FREE);
    sts.addr_ok   = (rem_r == '0) && (q_r != '0) &&
                    ({1'b0, h_full} < (DIV_W + 1)'(HEAP_BLOCKS));
    sts.rd_used   = (rd_kind == KIND_USED);
    sts.rd_free   = (rd_kind == KIND_FREE);
    sts.fit       = (rd_kind == KIND_FREE) && (DIV_W'(rd_size) >= q_r);
    sts.scan_end  = (adv >= HEAP_P);
    sts.nxt_in    = (adv < HEAP_P);
    sts.h_zero    = (h_r == '0);
    sts.walk_more = (adv < h_r);
    sts.prev_hit  = (adv == h_r) && (rd_kind == KIND_FREE);
    sts.clr_last  = (p_r == PW'(HEAP_BLOCKS - 1));
  end

  // Memory port control.
  always_comb begin
    we    = 1'b0;
    waddr = p_r[AW-1:0];
    wdata = '0;
    raddr = adv[AW-1:0];
    unique case (cmd.op)
      OP_CLEAR: begin
        we    = 1'b1;
        wdata = (p_r == '0) ? {KIND_FREE, FULL_SZ} : '0;
      end
      OP_F_CHECK:  raddr = h_full[AW-1:0];
      OP_F_HEAD: begin
        we    = (rd_kind == KIND_USED);
        waddr = h_r[AW-1:0];
        wdata = {KIND_FREE, rd_size};
      end
      OP_F_NEXT: begin
        we    = (rd_kind == KIND_FREE);
        waddr = h_r[AW-1:0];
        wdata = {KIND_FREE, merged};
      end
      OP_F_NCLR:   we = 1'b1;
      OP_F_WSTART: raddr = '0;
      OP_F_WALK: begin
        we    = sts.prev_hit;
        wdata = {KIND_FREE, merged};
      end
      OP_F_PCLR: begin
        we    = 1'b1;
        waddr = h_r[AW-1:0];
      end
      OP_A_START:  raddr = '0;
      OP_A_SCAN: begin
        we    = sts.fit && (DIV_W'(rd_size) > q_r);
        waddr = p_r[AW-1:0] + AW'(q_r) + AW'(1);
        wdata = {KIND_FREE, rd_size - SW'(q_r) - SW'(1)};
      end
      OP_A_MARK: begin
        we    = 1'b1;
        wdata = {KIND_USED, SW'(q_r)};
      end
      default: we = 1'b0;
    endcase
  end

  // Walk pointer, which also sweeps the memory after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r <= '0;
    end else begin
      case (cmd.op)
        OP_CLEAR:    p_r <= p_r + PW'(1);
        OP_F_HEAD:   p_r <= adv;
        OP_F_WSTART: p_r <= '0;
        OP_F_WALK:   p_r <= adv;
        OP_A_START:  p_r <= '0;
        OP_A_SCAN:   if (!sts.fit) p_r <= adv;
        default:     p_r <= p_r;
      endcase
    end
  end

  // Request registers, divider and freed segment bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 1'b0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          mode_r <= in_mode;
          x_r    <= (in_mode == MODE_FREE) ? {1'b0, in_free_address}
                                           : {1'b0, in_request_bytes} + BB_M1;
          cnt_r  <= 1'b0;
        end
        OP_DIV: begin
          if (!cnt_r) begin
            q_r   <= quot;
            cnt_r <= 1'b1;
          end else begin
            rem_r <= rem_calc[RB-1:0];
          end
        end
        OP_F_CHECK: h_r <= h_full[PW-1:0];
        OP_F_HEAD:  size_h_r <= rd_size;
        OP_F_NEXT:  if (rd_kind == KIND_FREE) size_h_r <= merged;
        default:    cnt_r <= cnt_r;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.res;
    end
    if (cmd.res) begin
      out_status_r <= cmd.status;
      out_addr_r   <= (cmd.status == ST_OK && mode_r == MODE_ALLOC) ?
                      addr_full[DATA_W-1:0] : '0;
    end
  end

  assign out_strobe          = out_strobe_r;
  assign out_status          = out_status_r;
  assign out_payload_address = out_addr_r;

  // The divider never runs past its last step.
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_DIV && sts.div_done) |=> (cmd.op != OP_DIV))
    else $error("divider ran past its last step");

endmodule

@@ bench/ffba_checker.sv @@
module ffba_checker #(
  parameter int BLOCK_BYTES = 64,
  parameter int HEAP_BLOCKS = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  logic                        in_mode,
  input  logic [ffba_pkg::DATA_W-1:0] in_request_bytes,
  input  logic [ffba_pkg::DATA_W-1:0] in_free_address,
  input  logic                        out_strobe,
  input  logic [1:0]                  out_status,
  input  logic [ffba_pkg::DATA_W-1:0] out_payload_address,
  output int                          fail_count,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import ffba_pkg::*;

  typedef struct {
    status_t     status;
    logic [15:0] addr;
  } heap_result_t;

  // Shadow copy of the heap headers.
  logic [1:0] shadow_kind [HEAP_BLOCKS];
  int         shadow_size [HEAP_BLOCKS];
  heap_result_t awaited_results [$];
  int mismatches;

  task automatic shadow_clear();
    for (int b = 0; b < HEAP_BLOCKS; b++) begin
      shadow_kind[b] = KIND_NONE;
      shadow_size[b] = 0;
    end
    shadow_kind[0] = KIND_FREE;
    shadow_size[0] = HEAP_BLOCKS - 1;
  endtask

  // First-fit search; any surplus is split off as a new free segment.
  function automatic heap_result_t heap_alloc(input int bytes);
    heap_result_t r;
    int need, i, sz, nxt;
    r.status = ST_NOFIT;
    r.addr = '0;
    need = (bytes + BLOCK_BYTES - 1) / BLOCK_BYTES;
    i = 0;
    while (i < HEAP_BLOCKS) begin
      sz = shadow_size[i];
      if (shadow_kind[i] == KIND_FREE && sz >= need) begin
        if (sz > need) begin
          nxt = i + need + 1;
          if (nxt < HEAP_BLOCKS) begin
            shadow_kind[nxt] = KIND_FREE;
            shadow_size[nxt] = sz - need - 1;
          end
          shadow_size[i] = need;
        end
        shadow_kind[i] = KIND_USED;
        r.status = ST_OK;
        r.addr = 16'(((i + 1) * BLOCK_BYTES) & 16'hFFFF);
        return r;
      end
      i += sz + 1;
    end
    return r;
  endfunction

  // Release a segment and merge it with free neighbours on both sides.
  function automatic heap_result_t heap_release(input int addr);
    heap_result_t r;
    int h, nxt, p, prev;
    bit have_prev;
    r.addr = '0;
    r.status = ST_INVALID;
    have_prev = 0;
    if (addr % BLOCK_BYTES != 0 || addr < BLOCK_BYTES) return r;
    h = addr / BLOCK_BYTES - 1;
    if (h >= HEAP_BLOCKS) return r;
    if (shadow_kind[h] != KIND_USED) return r;
    shadow_kind[h] = KIND_FREE;
    nxt = h + shadow_size[h] + 1;
    if (nxt < HEAP_BLOCKS && shadow_kind[nxt] == KIND_FREE) begin
      shadow_size[h] += shadow_size[nxt] + 1;
      shadow_kind[nxt] = KIND_NONE;
      shadow_size[nxt] = 0;
    end
    p = 0;
    prev = 0;
    while (p < h) begin
      prev = p;
      have_prev = 1;
      p += shadow_size[p] + 1;
    end
    if (have_prev && p == h && shadow_kind[prev] == KIND_FREE) begin
      shadow_size[prev] += shadow_size[h] + 1;
      shadow_kind[h] = KIND_NONE;
      shadow_size[h] = 0;
    end
    r.status = ST_OK;
    return r;
  endfunction

  // Predict on each accepted request, then compare any result strobed out.
  always @(posedge clk) begin
    heap_result_t want;
    if (!rst_n) begin
      shadow_clear();
      awaited_results.delete();
    end else begin
      if (start && !busy) begin
        if (in_mode == MODE_ALLOC) want = heap_alloc(int'(in_request_bytes));
        else want = heap_release(int'(in_free_address));
        awaited_results.push_back(want);
      end
      if (out_strobe) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: status %0d addr %0d", out_status, out_payload_address);
        end else begin
          want = awaited_results.pop_front();
          if (out_status !== want.status || out_payload_address !== want.addr) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected status %0d addr %0d, got status %0d addr %0d",
                       want.status, want.addr, out_status, out_payload_address);
          end
        end
      end
    end
  end

  initial mismatches = 0;
  assign pending = awaited_results.size();
  assign fail_count = mismatches;
endmodule

@@ bench/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ffba_pkg::*;

  localparam int BLOCK_BYTES = 64;
  localparam int HEAP_BLOCKS = 1024;
  localparam int CYCLE_LIMIT = 3_000_000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic        in_mode = MODE_ALLOC;
  logic [15:0] in_request_bytes = '0;
  logic [15:0] in_free_address = '0;
  logic        out_strobe;
  logic [1:0]  out_status;
  logic [15:0] out_payload_address;
  int          fail_count, pending;

  int          cycles = 0;
  int          n_ok = 0, n_nofit = 0, n_invalid = 0;
  logic [15:0] live_addrs [$];
  int          gap_pct = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  first_fit_block_allocator #(.BLOCK_BYTES(BLOCK_BYTES), .HEAP_BLOCKS(HEAP_BLOCKS)) uut (.*);

  ffba_checker #(.BLOCK_BYTES(BLOCK_BYTES), .HEAP_BLOCKS(HEAP_BLOCKS)) chk (
    .clk, .rst_n, .start, .busy, .in_mode, .in_request_bytes, .in_free_address,
    .out_strobe, .out_status, .out_payload_address, .fail_count, .pending);

  // Watchdog, and a record of granted addresses to aim free requests at.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
    if (rst_n && out_strobe) begin
      if (out_status == ST_OK) n_ok++;
      else if (out_status == ST_NOFIT) n_nofit++;
      else n_invalid++;
      if (out_status == ST_OK && out_payload_address != 0)
        live_addrs.push_back(out_payload_address);
    end
  end

  // Present one request from a falling edge and hold it until accepted.
  task automatic send(input logic mode, input logic [15:0] bytes, input logic [15:0] addr);
    int g;
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      start = 0;
      g = $urandom_range(1, 12);
      repeat (g) @(negedge clk);
    end
    in_mode = mode;
    in_request_bytes = bytes;
    in_free_address = addr;
    start = 1;
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic send_random();
    int k;
    logic [15:0] a;
    if ($urandom_range(99) < 55) begin
      k = $urandom_range(99);
      if (k < 80) send(MODE_ALLOC, 16'($urandom_range(0, 640)), 16'($urandom));
      else if (k < 92) send(MODE_ALLOC, 16'($urandom_range(0, 8192)), 16'($urandom));
      else send(MODE_ALLOC, 16'($urandom), 16'($urandom));
    end else begin
      k = $urandom_range(99);
      if (k < 75 && live_addrs.size() > 0) begin
        k = $urandom_range(live_addrs.size() - 1);
        a = live_addrs[k];
        live_addrs.delete(k);
        send(MODE_FREE, 16'($urandom), a);
      end else if (k < 88) begin
        send(MODE_FREE, 16'($urandom), 16'($urandom_range(1, 1023) * BLOCK_BYTES));
      end else begin
        send(MODE_FREE, 16'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n = 1;

    // Directed requests: full heap, bad addresses, header-only and one-surplus splits.
    send(MODE_ALLOC, 16'd65472, 16'd0);
    send(MODE_ALLOC, 16'd0, 16'd0);
    send(MODE_FREE, 16'hFFFF, 16'd64);
    send(MODE_FREE, 16'd0, 16'd0);
    send(MODE_FREE, 16'd0, 16'd32);
    send(MODE_FREE, 16'd0, 16'd63);
    send(MODE_FREE, 16'd0, 16'hFFFF);
    send(MODE_FREE, 16'd0, 16'd64);
    send(MODE_ALLOC, 16'd0, 16'hFFFF);
    send(MODE_ALLOC, 16'd1, 16'd0);
    send(MODE_ALLOC, 16'd64, 16'd0);
    send(MODE_FREE, 16'd0, 16'd128);
    send(MODE_ALLOC, 16'd0, 16'd0);
    send(MODE_FREE, 16'd0, 16'd192);
    send(MODE_FREE, 16'd0, 16'd320);
    send(MODE_FREE, 16'd0, 16'd256);
    send(MODE_ALLOC, 16'hFFFF, 16'd0);
    send(MODE_ALLOC, 16'd65, 16'd0);
    send(MODE_FREE, 16'd0, 16'd65472);
    send(MODE_FREE, 16'd0, 16'd64);
    live_addrs.delete();

    // Random requests in three idling phases.
    for (int n = 0; n < 520; n++) begin
      gap_pct = (n < 173) ? 8 : (n < 346) ? 48 : 0;
      if (n == 260) begin
        start = 0;
        while (pending != 0) @(negedge clk);
      end
      send_random();
    end
    start = 0;

    while (pending != 0) @(negedge clk);
    repeat (64) @(negedge clk);
    $display("Covered %0d requests: %0d granted or released, %0d without a fit, %0d refused.",
             n_ok + n_nofit + n_invalid, n_ok, n_nofit, n_invalid);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
